// ===== sv/owbm_pkg.sv =====
// Package for the 1-Wire bus master: operation codes, phase encoding,
// register indexes, the timing register bundle and small helper functions.
// Depends on nothing; used by every module of the block but owbm_checker.
package owbm_pkg;

    // Operation codes carried by each tick request
    localparam logic [1:0] OP_NONE  = 2'd0;
    localparam logic [1:0] OP_RESET = 2'd1;
    localparam logic [1:0] OP_WRITE = 2'd2;
    localparam logic [1:0] OP_READ  = 2'd3;

    // Configuration register indexes
    localparam int unsigned CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] REG_RESET_LOW     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PRESENCE_SMP  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_RESET_RECOV   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SLOT_LOW      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_READ_SMP      = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_SLOT_TICKS    = 3'd5;

    localparam int unsigned CFG_DATA_W = 10;

    // Register defaults
    localparam logic [9:0] DEF_RESET_LOW    = 10'd500;
    localparam logic [9:0] DEF_PRESENCE_SMP = 10'd30;
    localparam logic [9:0] DEF_RESET_RECOV  = 10'd300;
    localparam logic [5:0] DEF_SLOT_LOW     = 6'd6;
    localparam logic [5:0] DEF_READ_SMP     = 6'd12;
    localparam logic [6:0] DEF_SLOT_TICKS   = 7'd46;

    // Reset sub-stages held in the bit index during a bus reset
    localparam logic [2:0] RST_STAGE_LOW    = 3'd0;
    localparam logic [2:0] RST_STAGE_SAMPLE = 3'd1;
    localparam logic [2:0] RST_STAGE_RECOV  = 3'd2;

    localparam logic [2:0] LAST_BIT = 3'd7;

    typedef enum logic [3:0] {
        PH_IDLE  = 4'b0001,
        PH_RESET = 4'b0010,
        PH_WRITE = 4'b0100,
        PH_READ  = 4'b1000
    } phase_t;

    typedef struct packed {
        logic [9:0] reset_low_ticks;
        logic [9:0] presence_sample_tick;
        logic [9:0] reset_recovery_ticks;
        logic [5:0] slot_low_ticks;
        logic [5:0] read_sample_tick;
        logic [6:0] slot_ticks;
    } cfg_t;

    // Treat a zero interval as one tick
    function automatic logic [9:0] min_one10(input logic [9:0] v);
        return (v == 10'd0) ? 10'd1 : v;
    endfunction

    function automatic logic [6:0] min_one7(input logic [6:0] v);
        return (v == 7'd0) ? 7'd1 : v;
    endfunction

endpackage

// ===== sv/owbm_cfg.sv =====
// Timing register file of the 1-Wire bus master.
// Depends on owbm_pkg for register indexes, defaults and the cfg_t bundle.
module owbm_cfg (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_we,
    input  logic [owbm_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [owbm_pkg::CFG_DATA_W-1:0]   cfg_wdata,
    output owbm_pkg::cfg_t                    cfg
);

    owbm_pkg::cfg_t cfg_reg;

    // Load defaults on reset, then take writes by index
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.reset_low_ticks      <= owbm_pkg::DEF_RESET_LOW;
            cfg_reg.presence_sample_tick <= owbm_pkg::DEF_PRESENCE_SMP;
            cfg_reg.reset_recovery_ticks <= owbm_pkg::DEF_RESET_RECOV;
            cfg_reg.slot_low_ticks       <= owbm_pkg::DEF_SLOT_LOW;
            cfg_reg.read_sample_tick     <= owbm_pkg::DEF_READ_SMP;
            cfg_reg.slot_ticks           <= owbm_pkg::DEF_SLOT_TICKS;
        end else if (cfg_we) begin
            unique case (cfg_index)
                owbm_pkg::REG_RESET_LOW:    cfg_reg.reset_low_ticks      <= cfg_wdata;
                owbm_pkg::REG_PRESENCE_SMP: cfg_reg.presence_sample_tick <= cfg_wdata;
                owbm_pkg::REG_RESET_RECOV:  cfg_reg.reset_recovery_ticks <= cfg_wdata;
                owbm_pkg::REG_SLOT_LOW:     cfg_reg.slot_low_ticks       <= cfg_wdata[5:0];
                owbm_pkg::REG_READ_SMP:     cfg_reg.read_sample_tick     <= cfg_wdata[5:0];
                owbm_pkg::REG_SLOT_TICKS:   cfg_reg.slot_ticks           <= cfg_wdata[6:0];
                default: ;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

// ===== sv/owbm_core.sv =====
// Tick engine of the 1-Wire bus master: input register, one step of the
// bus sequencer per tick, and the result register toward the receiver.
// Depends on owbm_pkg for codes, the phase type and the cfg_t bundle.
module owbm_core (
    input  logic            aclk,
    input  logic            aresetn,
    input  owbm_pkg::cfg_t  cfg,
    input  logic            s_valid,
    output logic            s_ready,
    input  logic [1:0]      s_operation,
    input  logic [7:0]      s_write_data,
    input  logic            s_line_in,
    output logic            m_valid,
    input  logic            m_ready,
    output logic            m_drive_low,
    output logic            m_busy_res,
    output logic            m_done_res,
    output logic            m_no_presence,
    output logic [7:0]      m_read_byte
);

    // Input stage
    logic        in_valid_reg;
    logic [1:0]  in_op_reg;
    logic [7:0]  in_wdata_reg;
    logic        in_line_reg;

    // Sequencer state
    owbm_pkg::phase_t phase_reg, phase_next;
    logic [9:0]  tick_reg, tick_next;
    logic [2:0]  bit_reg, bit_next;
    logic [7:0]  shift_reg, shift_next;
    logic        presence_reg, presence_next;
    logic [7:0]  last_read_reg, last_read_next;

    // Result stage
    logic        out_valid_reg;
    logic        out_drive_reg;
    logic        out_busy_reg;
    logic        out_done_reg;
    logic        out_presence_reg;
    logic [7:0]  out_read_reg;

    logic        drive_next;
    logic        done_next;
    logic        advance;

    // Move a request on when the result slot is free or being emptied
    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;

    // One tick of the bus sequencer
    always_comb begin
        owbm_pkg::phase_t ph;
        logic [9:0]  tc;
        logic [2:0]  bi;
        logic [7:0]  sb;
        logic [10:0] tc_inc;
        logic [6:0]  len;
        logic [6:0]  when_smp;
        logic        bit_val;
        logic        slot_end;

        ph         = phase_reg;
        tc         = tick_reg;
        bi         = bit_reg;
        sb         = shift_reg;
        presence_next  = presence_reg;
        last_read_next = last_read_reg;
        drive_next = 1'b0;
        done_next  = 1'b0;
        slot_end   = 1'b0;

        // Start a command only from idle
        if (ph == owbm_pkg::PH_IDLE && in_op_reg != owbm_pkg::OP_NONE) begin
            unique case (in_op_reg)
                owbm_pkg::OP_RESET: ph = owbm_pkg::PH_RESET;
                owbm_pkg::OP_WRITE: ph = owbm_pkg::PH_WRITE;
                owbm_pkg::OP_READ:  ph = owbm_pkg::PH_READ;
                default:            ph = owbm_pkg::PH_IDLE;
            endcase
            tc = 10'd0;
            bi = 3'd0;
            sb = (in_op_reg == owbm_pkg::OP_WRITE) ? in_wdata_reg : 8'd0;
        end

        tc_inc   = {1'b0, tc} + 11'd1;
        len      = owbm_pkg::min_one7(cfg.slot_ticks);
        when_smp = ({1'b0, cfg.read_sample_tick} < len) ?
                   {1'b0, cfg.read_sample_tick} : (len - 7'd1);
        bit_val  = sb[bi];

        unique case (ph)
            owbm_pkg::PH_RESET: begin
                tc = tc_inc[9:0];
                if (bi == owbm_pkg::RST_STAGE_LOW) begin
                    drive_next = 1'b1;
                    if (tc_inc >= {1'b0, owbm_pkg::min_one10(cfg.reset_low_ticks)}) begin
                        bi = owbm_pkg::RST_STAGE_SAMPLE;
                        tc = 10'd0;
                    end
                end else if (bi == owbm_pkg::RST_STAGE_SAMPLE) begin
                    if (tc_inc >=
                        {1'b0, owbm_pkg::min_one10(cfg.presence_sample_tick)}) begin
                        presence_next = in_line_reg;
                        bi = owbm_pkg::RST_STAGE_RECOV;
                        tc = 10'd0;
                    end
                end else begin
                    if (tc_inc >=
                        {1'b0, owbm_pkg::min_one10(cfg.reset_recovery_ticks)}) begin
                        bi = owbm_pkg::RST_STAGE_LOW;
                        tc = 10'd0;
                        done_next = 1'b1;
                    end
                end
            end
            owbm_pkg::PH_WRITE: begin
                if (tc < {4'd0, cfg.slot_low_ticks}) begin
                    drive_next = 1'b1;
                end else if (!bit_val && tc_inc < {4'd0, len}) begin
                    drive_next = 1'b1;
                end
                tc = tc_inc[9:0];
                slot_end = (tc_inc >= {4'd0, len});
            end
            owbm_pkg::PH_READ: begin
                if (tc < {4'd0, cfg.slot_low_ticks}) begin
                    drive_next = 1'b1;
                end
                if (tc == {3'd0, when_smp}) begin
                    sb = {in_line_reg, sb[7:1]};
                end
                tc = tc_inc[9:0];
                slot_end = (tc_inc >= {4'd0, len});
            end
            default: ;
        endcase

        // Close the bit slot and step to the next bit
        if (slot_end) begin
            tc = 10'd0;
            if (bi == owbm_pkg::LAST_BIT) begin
                bi = 3'd0;
                done_next = 1'b1;
                if (ph == owbm_pkg::PH_READ) begin
                    last_read_next = sb;
                end
            end else begin
                bi = bi + 3'd1;
            end
        end

        if (done_next) begin
            ph = owbm_pkg::PH_IDLE;
        end

        phase_next = ph;
        tick_next  = tc;
        bit_next   = bi;
        shift_next = sb;
    end

    // Input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            in_op_reg    <= s_operation;
            in_wdata_reg <= s_write_data;
            in_line_reg  <= s_line_in;
        end
    end

    // Sequencer state, advanced once per request
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg     <= owbm_pkg::PH_IDLE;
            tick_reg      <= 10'd0;
            bit_reg       <= 3'd0;
            shift_reg     <= 8'd0;
            presence_reg  <= 1'b1;
            last_read_reg <= 8'd0;
        end else if (advance) begin
            phase_reg     <= phase_next;
            tick_reg      <= tick_next;
            bit_reg       <= bit_next;
            shift_reg     <= shift_next;
            presence_reg  <= presence_next;
            last_read_reg <= last_read_next;
        end
    end

    // Result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_drive_reg    <= drive_next;
            out_busy_reg     <= (phase_next != owbm_pkg::PH_IDLE);
            out_done_reg     <= done_next;
            out_presence_reg <= presence_next;
            out_read_reg     <= last_read_next;
        end
    end

    assign m_valid       = out_valid_reg;
    assign m_drive_low   = out_drive_reg;
    assign m_busy_res    = out_busy_reg;
    assign m_done_res    = out_done_reg;
    assign m_no_presence = out_presence_reg;
    assign m_read_byte   = out_read_reg;

endmodule

// ===== sv/one_wire_bus_master.sv =====
// 1-Wire bus master, top level.
// Usage: each request on the s_ channel is one microsecond tick. It carries
// the sampled bus level (s_line_in) and, while the master is idle, a command
// (s_operation: none, bus reset, write byte, read byte; s_write_data for a
// write). Commands that arrive while a command runs are dropped. The tick
// that takes a command is already its first tick.
// Every request yields exactly one result on the m_ channel: the line drive
// for that tick (m_drive_low; the master only pulls low or releases), busy and
// done flags, the presence result of the last bus reset and the last byte read.
// A request passes the input register, then the result register; the
// sequencer step sits between them. Throughput: one request per cycle while
// m_ready holds high, set by the combinational sequencer step.
// Stall: while m_ready is low the result holds and one more request can
// wait in the input register; after that s_ready drops.
// Reset (aresetn, synchronous, low): both stages empty, sequencer idle, timing
// registers at their defaults, presence reads as no device, read byte zero.
// User writes timing registers via cfg_we/cfg_index/cfg_wdata only while idle;
// the block does not enforce it. Depends on owbm_pkg, owbm_cfg and owbm_core.
module one_wire_bus_master (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_we,
    input  logic [owbm_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [owbm_pkg::CFG_DATA_W-1:0]   cfg_wdata,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic [1:0]                        s_operation,
    input  logic [7:0]                        s_write_data,
    input  logic                              s_line_in,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic                              m_drive_low,
    output logic                              m_busy_res,
    output logic                              m_done_res,
    output logic                              m_no_presence,
    output logic [7:0]                        m_read_byte
);

    owbm_pkg::cfg_t cfg;

    // Timing registers
    owbm_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    // Tick engine
    owbm_core u_core (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg           (cfg),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_operation   (s_operation),
        .s_write_data  (s_write_data),
        .s_line_in     (s_line_in),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_drive_low   (m_drive_low),
        .m_busy_res    (m_busy_res),
        .m_done_res    (m_done_res),
        .m_no_presence (m_no_presence),
        .m_read_byte   (m_read_byte)
    );

endmodule

// ===== sv/owbm_checker.sv =====
// Port-level checks for the 1-Wire bus master, bound to the top level.
// Depends only on the ports of one_wire_bus_master.
module owbm_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       m_valid,
    input logic       m_ready,
    input logic       m_drive_low,
    input logic       m_busy_res,
    input logic       m_done_res,
    input logic       m_no_presence,
    input logic [7:0] m_read_byte
);

    // Hold a stalled result
    a_result_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_drive_low) && $stable(m_busy_res)
            && $stable(m_done_res) && $stable(m_no_presence) && $stable(m_read_byte))
        else $error("stalled result changed");

    // Drop all results on reset
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid right after reset");

    // Finishing tick is never busy
    a_done_not_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_done_res |-> !m_busy_res)
        else $error("done with busy set");

    // Idle tick releases the line
    a_idle_release: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_busy_res && !m_done_res |-> !m_drive_low)
        else $error("line driven while idle");

endmodule

bind one_wire_bus_master owbm_checker u_owbm_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .m_valid       (m_valid),
    .m_ready       (m_ready),
    .m_drive_low   (m_drive_low),
    .m_busy_res    (m_busy_res),
    .m_done_res    (m_done_res),
    .m_no_presence (m_no_presence),
    .m_read_byte   (m_read_byte)
);

// ===== verif/one_wire_bus_master_tb.sv =====
// Self-checking testbench for the 1-Wire bus master: directed tick table, fixed timing
// corners and random command streams, results held to table rows or an in-bench bus model.
// Depends on owbm_pkg and the one_wire_bus_master RTL.
module one_wire_bus_master_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned RANDOM_TICKS  = 500;
    localparam int unsigned PHASE_TICKS   = 110;
    localparam int unsigned HOLD_CYCLES   = 60;
    localparam int unsigned SETTLE_CYCLES = 4;
    localparam int unsigned CYCLE_LIMIT   = 2_000_000;
    localparam int unsigned REPORT_CAP    = 30;
    localparam logic [7:0]  UNTIL_IDLE    = 8'd0;
    localparam int unsigned DIR_ROWS      = 24;

    // Indexes past the last timing register; writes there must have no effect
    localparam logic [owbm_pkg::CFG_IDX_W-1:0] REG_SPARE_LO = 3'd6;
    localparam logic [owbm_pkg::CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;

    typedef struct packed {
        logic       drive_low;
        logic       busy;
        logic       done;
        logic       no_presence;
        logic [7:0] read_byte;
    } bus_out_t;

    typedef struct packed {
        logic [1:0] op;
        logic [7:0] wdata;
        logic       line;
        logic [7:0] reps;
        logic       typed;
        bus_out_t   want;
    } tick_row_t;

    typedef enum logic [1:0] {PACE_SEND_LIGHT, PACE_RECV_LIGHT, PACE_NO_IDLE} pace_t;

    logic                            aclk = 1'b0;
    logic                            aresetn;
    logic                            cfg_we;
    logic [owbm_pkg::CFG_IDX_W-1:0]  cfg_index;
    logic [owbm_pkg::CFG_DATA_W-1:0] cfg_wdata;
    logic                            s_valid;
    logic                            s_ready;
    logic [1:0]                      s_operation;
    logic [7:0]                      s_write_data;
    logic                            s_line_in;
    logic                            m_valid;
    logic                            m_ready;
    logic                            m_drive_low;
    logic                            m_busy_res;
    logic                            m_done_res;
    logic                            m_no_presence;
    logic [7:0]                      m_read_byte;

    // Bus model state and its copy of the timing registers
    owbm_pkg::cfg_t   timing;
    owbm_pkg::phase_t seq_phase;
    logic [9:0]       seq_ticks;
    logic [2:0]       seq_bit;
    logic [7:0]       seq_shift;
    logic             seq_absent;
    logic [7:0]       seq_last_read;

    bus_out_t    pending_bus_out [$];
    tick_row_t   dir_rows [DIR_ROWS];
    pace_t       pace = PACE_SEND_LIGHT;
    int unsigned send_gap_pct = 15;
    int unsigned recv_gap_pct = 59;
    int unsigned ticks_sent;
    int unsigned ticks_seen;
    int unsigned fault_count;
    int unsigned timing_sets;
    int unsigned cycle_count;
    int unsigned cmd_count [4];

    one_wire_bus_master uut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_operation   (s_operation),
        .s_write_data  (s_write_data),
        .s_line_in     (s_line_in),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_drive_low   (m_drive_low),
        .m_busy_res    (m_busy_res),
        .m_done_res    (m_done_res),
        .m_no_presence (m_no_presence),
        .m_read_byte   (m_read_byte)
    );

    always #5 aclk = ~aclk;

    // Abort a hung run
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles, %0d results outstanding", cycle_count,
                     pending_bus_out.size());
            $display("TEST FAILED");
            $finish;
        end
    end

    task automatic report_mismatch(input string field, input logic [7:0] got,
                                   input logic [7:0] want);
        if (fault_count < REPORT_CAP)
            $display("Mismatch at result %0d: %s got %h want %h", ticks_seen, field, got, want);
        fault_count++;
    endtask

    function automatic int unsigned at_least_one(input int unsigned v);
        return (v == 0) ? 1 : v;
    endfunction

    // Close a bit slot; report whether the byte is complete
    function automatic logic finish_slot();
        seq_ticks = '0;
        if (seq_bit == owbm_pkg::LAST_BIT) begin
            seq_bit = '0;
            return 1'b1;
        end
        seq_bit = seq_bit + 3'd1;
        return 1'b0;
    endfunction

    // Advance the bus model by one tick and return the outputs for that tick
    function automatic bus_out_t predict_bus_tick(input logic [1:0] op, input logic [7:0] wdata,
                                                  input logic line);
        int unsigned slot_len;
        int unsigned sample_at;
        logic        pull;
        logic        fin;
        bus_out_t    o;
        pull = 1'b0;
        fin  = 1'b0;
        // Take a command only while idle
        if (seq_phase == owbm_pkg::PH_IDLE && op != owbm_pkg::OP_NONE) begin
            case (op)
                owbm_pkg::OP_RESET: seq_phase = owbm_pkg::PH_RESET;
                owbm_pkg::OP_WRITE: seq_phase = owbm_pkg::PH_WRITE;
                default:            seq_phase = owbm_pkg::PH_READ;
            endcase
            seq_ticks = '0;
            seq_bit   = '0;
            seq_shift = (op == owbm_pkg::OP_WRITE) ? wdata : 8'h00;
        end
        slot_len  = at_least_one(timing.slot_ticks);
        sample_at = (timing.read_sample_tick < slot_len) ? timing.read_sample_tick
                                                         : slot_len - 1;
        case (seq_phase)
            owbm_pkg::PH_RESET: begin
                seq_ticks = seq_ticks + 10'd1;
                if (seq_bit == owbm_pkg::RST_STAGE_LOW) begin
                    pull = 1'b1;
                    if (seq_ticks >= at_least_one(timing.reset_low_ticks)) begin
                        seq_bit   = owbm_pkg::RST_STAGE_SAMPLE;
                        seq_ticks = '0;
                    end
                end else if (seq_bit == owbm_pkg::RST_STAGE_SAMPLE) begin
                    if (seq_ticks >= at_least_one(timing.presence_sample_tick)) begin
                        seq_absent = line;
                        seq_bit    = owbm_pkg::RST_STAGE_RECOV;
                        seq_ticks  = '0;
                    end
                end else if (seq_ticks >= at_least_one(timing.reset_recovery_ticks)) begin
                    seq_bit   = owbm_pkg::RST_STAGE_LOW;
                    seq_ticks = '0;
                    fin       = 1'b1;
                end
            end
            owbm_pkg::PH_WRITE: begin
                // Low part, then hold low for a zero bit except on the last tick
                if (seq_ticks < timing.slot_low_ticks)
                    pull = 1'b1;
                else if (!seq_shift[seq_bit] && seq_ticks + 1 < slot_len)
                    pull = 1'b1;
                seq_ticks = seq_ticks + 10'd1;
                if (seq_ticks >= slot_len)
                    fin = finish_slot();
            end
            owbm_pkg::PH_READ: begin
                if (seq_ticks < timing.slot_low_ticks)
                    pull = 1'b1;
                if (seq_ticks == sample_at)
                    seq_shift = {line, seq_shift[7:1]};
                seq_ticks = seq_ticks + 10'd1;
                if (seq_ticks >= slot_len) begin
                    fin = finish_slot();
                    if (fin)
                        seq_last_read = seq_shift;
                end
            end
            default: ;
        endcase
        if (fin)
            seq_phase = owbm_pkg::PH_IDLE;
        o.drive_low   = pull;
        o.busy        = (seq_phase != owbm_pkg::PH_IDLE);
        o.done        = fin;
        o.no_presence = seq_absent;
        o.read_byte   = seq_last_read;
        return o;
    endfunction

    // flags holds drive_low, busy, done and no_presence in that order
    function automatic tick_row_t row(input logic [1:0] op, input logic [7:0] wdata,
                                      input logic line, input logic [7:0] reps,
                                      input logic typed, input logic [3:0] flags,
                                      input logic [7:0] rb);
        tick_row_t r;
        r.op    = op;
        r.wdata = wdata;
        r.line  = line;
        r.reps  = reps;
        r.typed = typed;
        r.want  = {flags, rb};
        return r;
    endfunction

    function automatic void set_pace(input pace_t p);
        pace = p;
        case (p)
            PACE_SEND_LIGHT: begin
                send_gap_pct = 15;
                recv_gap_pct = 59;
            end
            PACE_RECV_LIGHT: begin
                send_gap_pct = 59;
                recv_gap_pct = 15;
            end
            default: begin
                send_gap_pct = 0;
                recv_gap_pct = 0;
            end
        endcase
    endfunction

    // Offer one tick request, hold it until accepted, then queue its expected result
    task automatic offer_tick(input logic [1:0] op, input logic [7:0] wdata, input logic line,
                              input logic typed, input bus_out_t want);
        bus_out_t guess;
        logic     was_idle;
        while ($urandom_range(99) < send_gap_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid      <= 1'b1;
        s_operation  <= op;
        s_write_data <= wdata;
        s_line_in    <= line;
        @(posedge aclk);
        while (!s_ready)
            @(posedge aclk);
        was_idle = (seq_phase == owbm_pkg::PH_IDLE);
        guess    = predict_bus_tick(op, wdata, line);
        if (was_idle && op != owbm_pkg::OP_NONE)
            cmd_count[op]++;
        pending_bus_out.push_back(typed ? want : guess);
        ticks_sent++;
    endtask

    // Start a command and keep ticking with noise commands until it finishes
    task automatic run_command(input logic [1:0] op);
        offer_tick(op, 8'($urandom_range(255)), 1'($urandom_range(1)), 1'b0, '0);
        if (op == owbm_pkg::OP_NONE) begin
            repeat ($urandom_range(3))
                offer_tick(owbm_pkg::OP_NONE, 8'($urandom_range(255)),
                           1'($urandom_range(1)), 1'b0, '0);
        end
        while (seq_phase != owbm_pkg::PH_IDLE)
            offer_tick(2'($urandom_range(3)), 8'($urandom_range(255)),
                       1'($urandom_range(1)), 1'b0, '0);
    endtask

    // Drop valid and wait until every result is back
    task automatic settle_bus();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending_bus_out.size() != 0)
            @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_timing_reg(input logic [owbm_pkg::CFG_IDX_W-1:0] idx,
                                    input logic [owbm_pkg::CFG_DATA_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
        @(posedge aclk);
        case (idx)
            owbm_pkg::REG_RESET_LOW:    timing.reset_low_ticks      = data;
            owbm_pkg::REG_PRESENCE_SMP: timing.presence_sample_tick = data;
            owbm_pkg::REG_RESET_RECOV:  timing.reset_recovery_ticks = data;
            owbm_pkg::REG_SLOT_LOW:     timing.slot_low_ticks       = data[5:0];
            owbm_pkg::REG_READ_SMP:     timing.read_sample_tick     = data[5:0];
            owbm_pkg::REG_SLOT_TICKS:   timing.slot_ticks           = data[6:0];
            default: ;
        endcase
    endtask

    // Load a full timing set, plus writes to the unused indexes
    task automatic load_timing(input logic [9:0] rl, input logic [9:0] ps, input logic [9:0] rr,
                               input logic [9:0] sl, input logic [9:0] rs, input logic [9:0] st);
        write_timing_reg(owbm_pkg::REG_RESET_LOW, rl);
        write_timing_reg(owbm_pkg::REG_PRESENCE_SMP, ps);
        write_timing_reg(owbm_pkg::REG_RESET_RECOV, rr);
        write_timing_reg(owbm_pkg::REG_SLOT_LOW, sl);
        write_timing_reg(owbm_pkg::REG_READ_SMP, rs);
        write_timing_reg(owbm_pkg::REG_SLOT_TICKS, st);
        write_timing_reg(REG_SPARE_LO, 10'($urandom_range(1023)));
        write_timing_reg(REG_SPARE_HI, 10'($urandom_range(1023)));
        cfg_we <= 1'b0;
        timing_sets++;
    endtask

    task automatic exercise_all_ops();
        run_command(owbm_pkg::OP_RESET);
        run_command(owbm_pkg::OP_WRITE);
        run_command(owbm_pkg::OP_READ);
        run_command(owbm_pkg::OP_NONE);
        settle_bus();
    endtask

    // Check each result against the oldest expectation
    always @(posedge aclk) begin : watch_results
        bus_out_t got;
        bus_out_t want;
        if (aresetn && m_valid && m_ready) begin
            got = {m_drive_low, m_busy_res, m_done_res, m_no_presence, m_read_byte};
            if (pending_bus_out.size() == 0) begin
                report_mismatch("unexpected result", got.read_byte, 8'h00);
            end else begin
                want = pending_bus_out.pop_front();
                if (got.drive_low !== want.drive_low)
                    report_mismatch("drive_low", {7'd0, got.drive_low},
                                    {7'd0, want.drive_low});
                if (got.busy !== want.busy)
                    report_mismatch("busy_res", {7'd0, got.busy}, {7'd0, want.busy});
                if (got.done !== want.done)
                    report_mismatch("done_res", {7'd0, got.done}, {7'd0, want.done});
                if (got.no_presence !== want.no_presence)
                    report_mismatch("no_presence", {7'd0, got.no_presence},
                                    {7'd0, want.no_presence});
                if (got.read_byte !== want.read_byte)
                    report_mismatch("read_byte", got.read_byte, want.read_byte);
            end
            ticks_seen++;
        end
    end

    // Result side: random stalls, plus one long hold-off once the free-running pace starts
    initial begin : result_sink
        bit held_off;
        held_off = 1'b0;
        m_ready <= 1'b0;
        forever begin
            @(posedge aclk);
            if (pace == PACE_NO_IDLE && s_valid && !held_off) begin
                held_off = 1'b1;
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
            end
            m_ready <= ($urandom_range(99) >= recv_gap_pct);
        end
    end

    initial begin : stimulus
        int unsigned rand_start;
        int unsigned rand_done;
        logic        wide;
        aresetn      <= 1'b0;
        cfg_we       <= 1'b0;
        cfg_index    <= '0;
        cfg_wdata    <= '0;
        s_valid      <= 1'b0;
        s_operation  <= owbm_pkg::OP_NONE;
        s_write_data <= '0;
        s_line_in    <= 1'b1;

        // Model state after reset
        timing.reset_low_ticks      = owbm_pkg::DEF_RESET_LOW;
        timing.presence_sample_tick = owbm_pkg::DEF_PRESENCE_SMP;
        timing.reset_recovery_ticks = owbm_pkg::DEF_RESET_RECOV;
        timing.slot_low_ticks       = owbm_pkg::DEF_SLOT_LOW;
        timing.read_sample_tick     = owbm_pkg::DEF_READ_SMP;
        timing.slot_ticks           = owbm_pkg::DEF_SLOT_TICKS;
        seq_phase     = owbm_pkg::PH_IDLE;
        seq_ticks     = '0;
        seq_bit       = '0;
        seq_shift     = '0;
        seq_absent    = 1'b1;
        seq_last_read = '0;
        foreach (cmd_count[i])
            cmd_count[i] = 0;

        // Directed ticks; flags are drive_low, busy, done, no_presence
        dir_rows[0]  = row(owbm_pkg::OP_NONE,  8'h00, 1'b1, 8'd3, 1'b1, 4'b0001, 8'h00);
        dir_rows[1]  = row(owbm_pkg::OP_NONE,  8'hFF, 1'b0, 8'd1, 1'b1, 4'b0001, 8'h00);
        dir_rows[2]  = row(owbm_pkg::OP_RESET, 8'h00, 1'b1, 8'd1, 1'b1, 4'b1101, 8'h00);
        dir_rows[3]  = row(owbm_pkg::OP_NONE,  8'h00, 1'b0, UNTIL_IDLE, 1'b0, 4'b0000, 8'h00);
        dir_rows[4]  = row(owbm_pkg::OP_NONE,  8'h00, 1'b1, 8'd1, 1'b1, 4'b0000, 8'h00);
        dir_rows[5]  = row(owbm_pkg::OP_RESET, 8'h00, 1'b1, 8'd1, 1'b1, 4'b1100, 8'h00);
        dir_rows[6]  = row(owbm_pkg::OP_WRITE, 8'hFF, 1'b1, 8'd1, 1'b1, 4'b1100, 8'h00);
        dir_rows[7]  = row(owbm_pkg::OP_NONE,  8'h00, 1'b1, UNTIL_IDLE, 1'b0, 4'b0000, 8'h00);
        dir_rows[8]  = row(owbm_pkg::OP_WRITE, 8'h00, 1'b1, 8'd1, 1'b1, 4'b1101, 8'h00);
        dir_rows[9]  = row(owbm_pkg::OP_READ,  8'hFF, 1'b0, UNTIL_IDLE, 1'b0, 4'b0000, 8'h00);
        dir_rows[10] = row(owbm_pkg::OP_WRITE, 8'hFF, 1'b0, 8'd1, 1'b1, 4'b1101, 8'h00);
        dir_rows[11] = row(owbm_pkg::OP_NONE,  8'h00, 1'b0, UNTIL_IDLE, 1'b0, 4'b0000, 8'h00);
        dir_rows[12] = row(owbm_pkg::OP_WRITE, 8'hA5, 1'b1, 8'd1, 1'b0, 4'b0000, 8'h00);
        dir_rows[13] = row(owbm_pkg::OP_RESET, 8'h5A, 1'b1, UNTIL_IDLE, 1'b0, 4'b0000, 8'h00);
        dir_rows[14] = row(owbm_pkg::OP_READ,  8'h00, 1'b1, 8'd1, 1'b1, 4'b1101, 8'h00);
        dir_rows[15] = row(owbm_pkg::OP_NONE,  8'h00, 1'b1, UNTIL_IDLE, 1'b0, 4'b0000, 8'h00);
        dir_rows[16] = row(owbm_pkg::OP_NONE,  8'h00, 1'b0, 8'd1, 1'b1, 4'b0001, 8'hFF);
        dir_rows[17] = row(owbm_pkg::OP_READ,  8'h00, 1'b0, 8'd1, 1'b0, 4'b0000, 8'h00);
        dir_rows[18] = row(owbm_pkg::OP_WRITE, 8'hFF, 1'b0, UNTIL_IDLE, 1'b0, 4'b0000, 8'h00);
        dir_rows[19] = row(owbm_pkg::OP_NONE,  8'h00, 1'b1, 8'd2, 1'b1, 4'b0001, 8'h00);
        dir_rows[20] = row(owbm_pkg::OP_READ,  8'hFF, 1'b1, 8'd1, 1'b0, 4'b0000, 8'h00);
        dir_rows[21] = row(owbm_pkg::OP_NONE,  8'h00, 1'b0, 8'd12, 1'b0, 4'b0000, 8'h00);
        dir_rows[22] = row(owbm_pkg::OP_NONE,  8'h00, 1'b1, UNTIL_IDLE, 1'b0, 4'b0000, 8'h00);
        dir_rows[23] = row(owbm_pkg::OP_NONE,  8'h00, 1'b0, 8'd1, 1'b1, 4'b0001, 8'hFC);

        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Short timing so each directed command stays brief; slot of 8, sample on tick 3
        load_timing(10'd20, 10'd5, 10'd10, 10'd2, 10'd3, 10'd8);

        set_pace(PACE_SEND_LIGHT);
        foreach (dir_rows[i]) begin
            if (dir_rows[i].reps == UNTIL_IDLE) begin
                do
                    offer_tick(dir_rows[i].op, dir_rows[i].wdata, dir_rows[i].line,
                               dir_rows[i].typed, dir_rows[i].want);
                while (seq_phase != owbm_pkg::PH_IDLE);
            end else begin
                repeat (dir_rows[i].reps)
                    offer_tick(dir_rows[i].op, dir_rows[i].wdata, dir_rows[i].line,
                               dir_rows[i].typed, dir_rows[i].want);
            end
        end
        settle_bus();

        // Timing corners: zero, narrowest legal, sample past slot end, sample inside
        // the low part, low part longer than the slot, values wider than their registers
        load_timing(10'd0, 10'd0, 10'd0, 10'd0, 10'd0, 10'd0);
        exercise_all_ops();
        load_timing(10'd1, 10'd1, 10'd1, 10'd1, 10'd1, 10'd2);
        exercise_all_ops();
        load_timing(10'd3, 10'd2, 10'd3, 10'd4, 10'd20, 10'd8);
        exercise_all_ops();
        load_timing(10'd2, 10'd3, 10'd2, 10'd6, 10'd2, 10'd9);
        exercise_all_ops();
        load_timing(10'd6, 10'd6, 10'd6, 10'd63, 10'd63, 10'd12);
        exercise_all_ops();
        load_timing(10'd5, 10'd4, 10'd3, 10'h3C5, 10'h2C3, 10'h28A);
        exercise_all_ops();

        // Random command streams under mostly short random timings, pace shifting by thirds
        rand_start = ticks_sent;
        while (ticks_sent - rand_start < RANDOM_TICKS) begin
            rand_done = ticks_sent - rand_start;
            if (rand_done >= 2 * RANDOM_TICKS / 3)
                set_pace(PACE_NO_IDLE);
            else if (rand_done >= RANDOM_TICKS / 3)
                set_pace(PACE_RECV_LIGHT);
            wide = ($urandom_range(9) == 0);
            load_timing(10'($urandom_range(12)), 10'($urandom_range(12)),
                        10'($urandom_range(12)),
                        wide ? 10'($urandom_range(1023)) : 10'($urandom_range(8)),
                        wide ? 10'($urandom_range(1023)) : 10'($urandom_range(14)),
                        wide ? {3'($urandom_range(7)), 7'($urandom_range(14))}
                             : 10'($urandom_range(14)));
            while (ticks_sent - rand_start - rand_done < PHASE_TICKS) begin
                case ($urandom_range(9))
                    0:       run_command(owbm_pkg::OP_NONE);
                    1, 2, 3: run_command(owbm_pkg::OP_RESET);
                    4, 5, 6: run_command(owbm_pkg::OP_WRITE);
                    default: run_command(owbm_pkg::OP_READ);
                endcase
            end
            settle_bus();
        end

        $display("Ran %0d bus ticks over %0d timing sets: %0d resets, %0d writes, %0d reads.",
                 ticks_sent, timing_sets, cmd_count[owbm_pkg::OP_RESET],
                 cmd_count[owbm_pkg::OP_WRITE], cmd_count[owbm_pkg::OP_READ]);
        $display("Checked %0d results, %0d mismatches.", ticks_seen, fault_count);
        if (fault_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

// ===== files.f =====
sv/owbm_pkg.sv
sv/owbm_cfg.sv
sv/owbm_core.sv
sv/one_wire_bus_master.sv
sv/owbm_checker.sv
verif/one_wire_bus_master_tb.sv
